// ===== design/vh3d_pkg.sv =====
// Shared types and constants of the voxel histogram block.
`timescale 1ns / 1ps

package vh3d_pkg;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned RADDR_W  = 12;
  localparam int unsigned OADDR_W  = 12;
  localparam int unsigned OCNT_W   = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z     = 3'd6;

  // Item kinds.
  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_READ     = 2'd1;
  localparam logic [1:0] KIND_READ_CLR = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [RADDR_W-1:0]       read_address;
  } in_beat_t;

  typedef struct packed {
    logic [OADDR_W-1:0] bin_address;
    logic [OCNT_W-1:0]  bin_count;
    logic               out_of_range;
  } out_beat_t;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_DIFF  = 9'b000000100,
    ST_CHECK = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_ACC   = 9'b000100000,
    ST_MREQ  = 9'b001000000,
    ST_MDATA = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

endpackage

// ===== design/vh3d_chan_if.sv =====
// Valid/ready channel interface carrying one payload beat.
`timescale 1ns / 1ps

interface vh3d_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/vh3d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vh3d_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/voxel_histogram_3d.sv =====
// Top level of the 3D voxel grid histogram.
`timescale 1ns / 1ps

// Voxel grid histogram. Each input beat is one of three kinds: add a point,
// read a bin, or read a bin and clear it. For an add the block subtracts the
// configured origin from each Q16.16 coordinate, floors the difference
// divided by cube_size into a bin number, checks it against the axis
// dimension, and forms the linear address x*dim_y*dim_z + y*dim_z + z by
// Horner steps. The addressed counter is incremented with saturation at
// 2^COUNT_WIDTH-1 and its new value is returned. Points below the origin,
// beyond a dimension or beyond the store come back with out_of_range set,
// address 0 and count 0, and nothing is counted. Every item except the unused
// kind 3 returns exactly one result beat; kind 3 is taken and dropped.
// Timing: one item is worked on at a time, and in_i.ready is high only while
// the block waits for a new item. An add goes per axis through the difference
// and the bound product, the bound check, the shared restoring divider (one
// quotient bit a cycle) and one multiply-accumulate step, then through the
// counter read and its write-back, and last the hand-over of the result, which
// waits while the output register still holds a result not yet taken. An
// out-of-range point ends early at the failing axis. A read goes through the
// counter read and, for read-and-clear, the clearing write before its hand-over.
// The block is ready for the next item in the cycle after a result is handed
// over to the output register. After reset the block clears the counter
// memory, one entry a cycle, and accepts no item until that pass is done;
// configuration writes are taken at any time. The output register lets the
// next item be accepted while a result still waits on out_o.ready.
// Configuration should only be written while no item is in flight.
module voxel_histogram_3d #(
  parameter int unsigned MAX_BINS    = 4096,
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vh3d_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vh3d_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  vh3d_chan_if.sink                       in_i,
  vh3d_chan_if.source                     out_o
);

  import vh3d_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_BINS);
  localparam int unsigned LINW   = $clog2(MAX_BINS + 1);
  localparam int unsigned CMPW   = (LINW > OADDR_W) ? LINW : OADDR_W;
  localparam int unsigned CCW    = (COUNT_WIDTH > OCNT_W) ? COUNT_WIDTH : OCNT_W;
  localparam int unsigned QUO_W  = DIM_W;
  localparam int unsigned ITER_W = $clog2(QUO_W);
  localparam int unsigned DVS_W  = STEP_W + QUO_W - 1;
  localparam int unsigned PROD_W = STEP_W + DIM_W;
  localparam int unsigned SUM_W  = LINW + DIM_W + 1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration registers.
  logic signed [POS_W-1:0] org_x_q, org_y_q, org_z_q;
  logic [STEP_W-1:0]       step_q;
  logic [DIM_W-1:0]        dim_x_q, dim_y_q, dim_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      step_q  <= STEP_W'(65536);
      dim_x_q <= DIM_W'(16);
      dim_y_q <= DIM_W'(16);
      dim_z_q <= DIM_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X:  org_x_q <= cfg_wdata_i;
        REG_ORIGIN_Y:  org_y_q <= cfg_wdata_i;
        REG_ORIGIN_Z:  org_z_q <= cfg_wdata_i;
        REG_CUBE_SIZE: step_q  <= cfg_wdata_i[STEP_W-1:0];
        REG_DIM_X:     dim_x_q <= cfg_wdata_i[DIM_W-1:0];
        REG_DIM_Y:     dim_y_q <= cfg_wdata_i[DIM_W-1:0];
        REG_DIM_Z:     dim_z_q <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A cube size of zero behaves as the smallest step.
  logic [STEP_W-1:0] step_eff;
  assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;

  // Sequencer state.
  state_e                  state_q, state_d;
  logic [1:0]              axis_q, axis_d;
  logic [ITER_W-1:0]       iter_q, iter_d;
  logic [1:0]              kind_q, kind_d;
  logic signed [POS_W-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [POS_W:0]          diff_q, diff_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [POS_W-1:0]        rem_q, rem_d;
  logic [DVS_W-1:0]        dvs_q, dvs_d;
  logic [QUO_W-1:0]        quo_q, quo_d;
  logic [LINW-1:0]         acc_q, acc_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [LINW-1:0]         clr_q, clr_d;
  out_beat_t               res_q, res_d;
  out_beat_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  // Per-axis operand selection.
  logic signed [POS_W-1:0] cur_pos, cur_org;
  logic [DIM_W-1:0]        cur_dim;

  always_comb begin
    case (axis_q)
      AXIS_X: begin
        cur_pos = px_q;
        cur_org = org_x_q;
        cur_dim = dim_x_q;
      end
      AXIS_Y: begin
        cur_pos = py_q;
        cur_org = org_y_q;
        cur_dim = dim_y_q;
      end
      default: begin
        cur_pos = pz_q;
        cur_org = org_z_q;
        cur_dim = dim_z_q;
      end
    endcase
  end

  // The one multiplier: bin bound (dim * step) or Horner step (acc * dim).
  logic [STEP_W-1:0] mul_a;
  logic [PROD_W-1:0] mul_p;
  assign mul_a = (state_q == ST_ACC) ? STEP_W'(acc_q) : step_eff;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(cur_dim);

  // Divider compare and Horner sum.
  logic            div_ge;
  logic [SUM_W-1:0] lin_sum;
  logic            lin_over;
  assign div_ge   = DVS_W'(rem_q) >= dvs_q;
  assign lin_sum  = SUM_W'(mul_p) + SUM_W'(quo_q);
  assign lin_over = lin_sum >= SUM_W'(MAX_BINS);

  // Counter memory and its read data.
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CCW-1:0]         cnt_wide;
  logic [CMPW-1:0]        idx_wide;
  logic [CMPW-1:0]        ra_wide;

  assign cnt_inc  = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
  assign idx_wide = CMPW'(idx_q);
  assign ra_wide  = CMPW'(in_i.data.read_address);

  logic in_fire, out_fire;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    iter_d      = iter_q;
    kind_d      = kind_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;
    cnt_wide    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        clr_d     = clr_q + LINW'(1);
        if (clr_q == LINW'(MAX_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          kind_d = in_i.data.kind;
          px_d   = in_i.data.pos_x;
          py_d   = in_i.data.pos_y;
          pz_d   = in_i.data.pos_z;
          axis_d = AXIS_X;
          acc_d  = '0;
          case (in_i.data.kind)
            KIND_ADD: begin
              state_d = ST_DIFF;
            end
            KIND_READ, KIND_READ_CLR: begin
              if (ra_wide < CMPW'(MAX_BINS)) begin
                idx_d   = ra_wide[AW-1:0];
                state_d = ST_MREQ;
              end else begin
                res_d.bin_address  = in_i.data.read_address;
                res_d.bin_count    = '0;
                res_d.out_of_range = 1'b1;
                state_d            = ST_FIN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIFF: begin
        diff_d  = {cur_pos[POS_W-1], cur_pos} - {cur_org[POS_W-1], cur_org};
        prod_d  = mul_p;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // The bin is in range exactly when 0 <= diff < dim * step.
        if (diff_q[POS_W] || (PROD_W'(diff_q[POS_W-1:0]) >= prod_q)) begin
          res_d.bin_address  = '0;
          res_d.bin_count    = '0;
          res_d.out_of_range = 1'b1;
          state_d            = ST_FIN;
        end else begin
          rem_d   = diff_q[POS_W-1:0];
          dvs_d   = {step_eff, {(QUO_W-1){1'b0}}};
          quo_d   = '0;
          iter_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_ge) begin
          rem_d = rem_q - dvs_q[POS_W-1:0];
        end
        quo_d  = {quo_q[QUO_W-2:0], div_ge};
        dvs_d  = dvs_q >> 1;
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(QUO_W - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        // Once past the store the sum is pinned, since later steps only grow.
        acc_d  = lin_over ? LINW'(MAX_BINS) : lin_sum[LINW-1:0];
        axis_d = axis_q + 2'd1;
        if (axis_q == AXIS_Z) begin
          if (lin_over) begin
            res_d.bin_address  = '0;
            res_d.bin_count    = '0;
            res_d.out_of_range = 1'b1;
            state_d            = ST_FIN;
          end else begin
            idx_d   = lin_sum[AW-1:0];
            state_d = ST_MREQ;
          end
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_MREQ: begin
        state_d = ST_MDATA;
      end
      ST_MDATA: begin
        if (kind_q == KIND_ADD) begin
          ram_we    = 1'b1;
          ram_wdata = cnt_inc;
          cnt_wide  = CCW'(cnt_inc);
        end else begin
          ram_we    = (kind_q == KIND_READ_CLR);
          cnt_wide  = CCW'(ram_rdata);
        end
        res_d.bin_address  = idx_wide[OADDR_W-1:0];
        res_d.bin_count    = cnt_wide[OCNT_W-1:0];
        res_d.out_of_range = 1'b0;
        state_d            = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      axis_q      <= AXIS_X;
      iter_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      iter_q      <= iter_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    px_q   <= px_d;
    py_q   <= py_d;
    pz_q   <= pz_d;
    diff_q <= diff_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    acc_q  <= acc_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  vh3d_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ===== sim/voxel_histogram_3d_test.sv =====
// Self-checking testbench for the 3D voxel grid histogram block.
`timescale 1ns / 1ps

// This bench feeds point, read and read-and-clear beats into the histogram and
// checks every result beat against a shadow copy of the grid kept here. The
// shadow holds its own origins, cube size, dimensions and all bin counters.
// Every accepted input beat is folded into the shadow at the moment it is
// accepted. The outcome is queued and compared field by field with the next
// result beat that leaves the block.
//
// The run has three parts. It first walks a short directed list at the reset
// grid (origin 0, cube 1.0, 16x16x16). That list covers empty reads, both
// corners of the grid, every way a point can miss the grid, read-and-clear,
// and the unused kind. Where the answer is plain, the list carries it by hand.
// It then runs a series of grid settings, each programmed while the block is
// idle and followed by a burst of random beats. The fixed settings cover the
// extreme origins and cube sizes, a zero cube size, a zero dimension, and
// dimensions whose product overruns the store. The random settings follow.
// Most random points are aimed at a chosen bin, or just one bin outside it, so
// that counters climb and the bound checks get hit from both sides.
module voxel_histogram_3d_test;
  import vh3d_pkg::*;

  localparam int unsigned MAX_BINS      = 4096;
  localparam int unsigned COUNT_WIDTH   = 20;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  // The block has no name for kind 3. It takes such a beat and drops it.
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  // This many quiet cycles cover any beat that is still in flight, including a
  // dropped kind 3 beat.
  localparam int unsigned SETTLE_CYCLES = 80;
  // The limit sits well above the slowest correct run: the clearing pass, then
  // about 400 beats with their input gaps and result stalls.
  localparam int unsigned LIMIT_CYCLES  = 500000;
  localparam int unsigned FIXED_GRIDS   = 6;
  localparam int unsigned GRID_PHASES   = 9;
  localparam int unsigned PHASE_BEATS   = 42;
  localparam int unsigned DIR_ROWS      = 23;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] cube;
    logic [31:0] dim_x;
    logic [31:0] dim_y;
    logic [31:0] dim_z;
  } grid_set_t;

  // One row of the directed list. When hand_checked is set, the typed answer
  // is what the result beat must show. Otherwise the shadow grid decides.
  typedef struct packed {
    in_beat_t  item;
    bit        hand_checked;
    out_beat_t answer;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DAT_W-1:0]  cfg_wdata;

  vh3d_chan_if #(.T(in_beat_t))  in_ch ();
  vh3d_chan_if #(.T(out_beat_t)) out_ch ();

  // Shadow of the grid settings and of the counter store.
  logic signed [31:0]     grid_origin [3];
  logic [STEP_W-1:0]      grid_step;
  logic [DIM_W-1:0]       grid_dim [3];
  logic [COUNT_WIDTH-1:0] shadow_counts [MAX_BINS];
  logic [RADDR_W-1:0]     recent_bin;

  out_beat_t   awaited_bins [$];
  out_beat_t   head_bin;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          idle_on;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // A counter that was never touched reads as zero, at both ends of the store.
    '{'{KIND_READ,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'd0},
      1'b1, '{12'd0, 20'd0, 1'b0}},
    '{'{KIND_READ_CLR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'd4095},
      1'b1, '{12'd4095, 20'd0, 1'b0}},
    // The origin corner, and then a point in the same cube just below 1.0.
    '{'{KIND_ADD,      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'd0},
      1'b1, '{12'd0, 20'd1, 1'b0}},
    '{'{KIND_ADD,      32'h0000_8000, 32'h0000_FFFF, 32'h0000_0001, 12'd0},
      1'b1, '{12'd0, 20'd2, 1'b0}},
    // The far corner of the grid is the last address of the store.
    '{'{KIND_ADD,      32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 12'd0},
      1'b1, '{12'd4095, 20'd1, 1'b0}},
    // Points that miss: exactly one cube past x, just below the origin on y,
    // the most negative z, and the most positive point of all.
    '{'{KIND_ADD,      32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 12'd0},
      1'b1, '{12'd0, 20'd0, 1'b1}},
    '{'{KIND_ADD,      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 12'd0},
      1'b1, '{12'd0, 20'd0, 1'b1}},
    '{'{KIND_ADD,      32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 12'd0},
      1'b1, '{12'd0, 20'd0, 1'b1}},
    '{'{KIND_ADD,      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0},
      1'b1, '{12'd0, 20'd0, 1'b1}},
    // Bin (1,2,3) sits at 1*256 + 2*16 + 3. It is read, cleared, then read again.
    '{'{KIND_ADD,      32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 12'd0},
      1'b1, '{12'd291, 20'd1, 1'b0}},
    '{'{KIND_READ,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'd291},
      1'b1, '{12'd291, 20'd1, 1'b0}},
    '{'{KIND_READ_CLR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'd291},
      1'b1, '{12'd291, 20'd1, 1'b0}},
    '{'{KIND_READ,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'd291},
      1'b1, '{12'd291, 20'd0, 1'b0}},
    // The unused kind is swallowed and gives no result beat.
    '{'{KIND_UNUSED,   32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 12'd291},
      1'b0, '{12'd0, 20'd0, 1'b0}},
    '{'{KIND_READ,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd0},
      1'b1, '{12'd0, 20'd2, 1'b0}},
    '{'{KIND_READ_CLR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'd0},
      1'b1, '{12'd0, 20'd2, 1'b0}},
    '{'{KIND_ADD,      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'hFFF},
      1'b1, '{12'd0, 20'd1, 1'b0}},
    '{'{KIND_READ,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'd4095},
      1'b1, '{12'd4095, 20'd1, 1'b0}},
    // Alternating bit patterns on the coordinates and the read address.
    '{'{KIND_ADD,      32'h000A_AAAA, 32'h0005_5555, 32'h000C_3333, 12'h555},
      1'b0, '{12'd0, 20'd0, 1'b0}},
    '{'{KIND_ADD,      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 12'hAAA},
      1'b1, '{12'd0, 20'd0, 1'b1}},
    '{'{KIND_READ,     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 12'hA5C},
      1'b0, '{12'd0, 20'd0, 1'b0}},
    '{'{KIND_READ_CLR, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 12'h555},
      1'b0, '{12'd0, 20'd0, 1'b0}},
    '{'{KIND_UNUSED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF},
      1'b0, '{12'd0, 20'd0, 1'b0}}
  };

  // Fixed grid settings, in order: a fine grid offset from zero; the extreme
  // origins with the largest cube; a zero cube size, which counts as the
  // smallest step; a zero y dimension; a single bin that starts at the most
  // negative origin; and three full dimensions that overrun the store.
  grid_set_t fixed_grids [FIXED_GRIDS] = '{
    '{32'hFFFD_8000, 32'hFFFF_0000, 32'h0003_4000, 32'h0000_4000, 32'd16, 32'd16, 32'd16},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'd4096, 32'd1, 32'd1},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd64, 32'd64, 32'd64},
    '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_8000, 32'h0001_0000, 32'd8, 32'd0, 32'd8},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'd4096, 32'd4096,
      32'd4096}
  };

  voxel_histogram_3d #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #5ns clk_i = ~clk_i;

  // Folds one accepted beat into the shadow grid. The return value is zero when
  // the beat produces no result.
  function automatic bit predict_histogram(input in_beat_t item, output out_beat_t res);
    logic signed [31:0] pos [3];
    longint             diff;
    longint unsigned    stp;
    longint unsigned    quot;
    longint unsigned    lin;
    longint unsigned    bin_no [3];
    bit                 in_grid;
    int                 a;
    res = '0;
    if (item.kind == KIND_UNUSED) return 1'b0;
    if (item.kind == KIND_ADD) begin
      pos[0]  = item.pos_x;
      pos[1]  = item.pos_y;
      pos[2]  = item.pos_z;
      stp     = (grid_step == '0) ? 64'd1 : 64'(grid_step);
      in_grid = 1'b1;
      for (a = 0; a < 3; a++) begin
        // The difference from the origin needs 33 bits. A negative one floors
        // to a negative bin, and a quotient at or past the dimension misses.
        diff = longint'(pos[a]) - longint'(grid_origin[a]);
        bin_no[a] = 0;
        if (diff < 0) begin
          in_grid = 1'b0;
        end else begin
          quot = $unsigned(diff) / stp;
          if (quot >= 64'(grid_dim[a])) in_grid = 1'b0;
          else bin_no[a] = quot;
        end
      end
      if (in_grid) begin
        lin = bin_no[0] * 64'(grid_dim[1]) * 64'(grid_dim[2])
            + bin_no[1] * 64'(grid_dim[2]) + bin_no[2];
        if (lin < 64'(MAX_BINS)) begin
          if (shadow_counts[lin[11:0]] != COUNT_MAX) begin
            shadow_counts[lin[11:0]] = shadow_counts[lin[11:0]] + 1'b1;
          end
          res.bin_address = lin[11:0];
          res.bin_count   = shadow_counts[lin[11:0]];
          recent_bin      = lin[11:0];
        end else begin
          res.out_of_range = 1'b1;
        end
      end else begin
        res.out_of_range = 1'b1;
      end
    end else begin
      // The read address is 12 bits wide, so it always lies inside the store.
      res.bin_address = item.read_address;
      res.bin_count   = shadow_counts[item.read_address];
      if (item.kind == KIND_READ_CLR) shadow_counts[item.read_address] = '0;
    end
    return 1'b1;
  endfunction

  // Most gaps are short or absent. A few are long enough to back the block up.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Builds a coordinate aimed at a chosen bin along one axis. Now and then it
  // aims one cube below the grid or one cube past the last bin.
  function automatic logic [31:0] near_axis(input int a);
    longint unsigned stp;
    longint          bin_no;
    longint          pos;
    int unsigned     roll;
    stp  = (grid_step == '0) ? 64'd1 : 64'(grid_step);
    roll = $urandom_range(0, 9);
    if (roll == 0) bin_no = -1;
    else if (roll == 1 || grid_dim[a] == '0) bin_no = longint'(grid_dim[a]);
    else bin_no = longint'($urandom_range(0, 32'(grid_dim[a]) - 1));
    pos = longint'(grid_origin[a]) + bin_no * longint'(stp)
        + longint'(64'($urandom) % stp);
    if (pos > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (pos < -64'sd2147483648) return 32'h8000_0000;
    return pos[31:0];
  endfunction

  function automatic in_beat_t make_item();
    in_beat_t    item;
    int unsigned roll;
    item.kind         = KIND_ADD;
    item.pos_x        = $urandom;
    item.pos_y        = $urandom;
    item.pos_z        = $urandom;
    item.read_address = RADDR_W'($urandom_range(0, MAX_BINS - 1));
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      item.pos_x = near_axis(0);
      item.pos_y = near_axis(1);
      item.pos_z = near_axis(2);
    end else if (roll < 65) begin
      // Leave the point fully random. It mostly misses and toggles every bit.
    end else if (roll < 93) begin
      item.kind = $urandom_range(0, 1) ? KIND_READ : KIND_READ_CLR;
      if ($urandom_range(0, 1)) item.read_address = recent_bin;
    end else begin
      item.kind = KIND_UNUSED;
    end
    return item;
  endfunction

  function automatic logic [31:0] rand_origin();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  // Dimension word with junk above bit 12, which the block must ignore.
  function automatic logic [31:0] rand_dim();
    logic [31:0] junk;
    int unsigned roll;
    junk = $urandom & 32'hFFFF_E000;
    roll = $urandom_range(0, 19);
    if (roll == 0) return junk;
    if (roll == 1) return junk | 32'd4096;
    return junk | $urandom_range(1, 16);
  endfunction

  function automatic grid_set_t random_grid();
    grid_set_t grid;
    grid.origin_x = rand_origin();
    grid.origin_y = rand_origin();
    grid.origin_z = rand_origin();
    case ($urandom_range(0, 4))
      0:       grid.cube = {1'($urandom_range(0, 1)), 31'd1};
      1:       grid.cube = 32'h0000_0100;
      2:       grid.cube = 32'h0001_0000;
      3:       grid.cube = $urandom;
      default: grid.cube = 32'h0001_8000;
    endcase
    grid.dim_x = rand_dim();
    grid.dim_y = rand_dim();
    grid.dim_z = rand_dim();
    return grid;
  endfunction

  // Drives one register write and updates the shadow settings to match.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_ORIGIN_X:  grid_origin[0] = value;
      REG_ORIGIN_Y:  grid_origin[1] = value;
      REG_ORIGIN_Z:  grid_origin[2] = value;
      REG_CUBE_SIZE: grid_step      = value[STEP_W-1:0];
      REG_DIM_X:     grid_dim[0]    = value[DIM_W-1:0];
      REG_DIM_Y:     grid_dim[1]    = value[DIM_W-1:0];
      REG_DIM_Z:     grid_dim[2]    = value[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_grid(input grid_set_t grid);
    write_reg(REG_ORIGIN_X, grid.origin_x);
    write_reg(REG_ORIGIN_Y, grid.origin_y);
    write_reg(REG_ORIGIN_Z, grid.origin_z);
    write_reg(REG_CUBE_SIZE, grid.cube);
    write_reg(REG_DIM_X, grid.dim_x);
    write_reg(REG_DIM_Y, grid.dim_y);
    write_reg(REG_DIM_Z, grid.dim_z);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Offers one beat after an optional gap and waits for it to be taken. Valid
  // is assigned at most once per falling edge. A beat that directly follows
  // the previous one keeps valid high and only swaps the payload.
  task automatic push_item(input in_beat_t item, input bit use_given,
                           input out_beat_t given);
    out_beat_t   res;
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (predict_histogram(item, res)) awaited_bins.push_back(use_given ? given : res);
  endtask

  // Holds the sender back until every queued result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (awaited_bins.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned row;
    int unsigned phase;
    int unsigned n;
    grid_set_t   grid;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    idle_on     = 1'b1;
    recent_bin  = '0;
    grid_origin = '{default: '0};
    grid_step   = STEP_W'(32'h0001_0000);
    grid_dim    = '{default: DIM_W'(16)};
    for (row = 0; row < MAX_BINS; row++) shadow_counts[row] = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The block sits in its clearing pass for a while. The first beat simply
    // waits for ready.
    for (row = 0; row < DIR_ROWS; row++) begin
      push_item(dir_rows[row].item, dir_rows[row].hand_checked, dir_rows[row].answer);
    end

    for (phase = 0; phase < GRID_PHASES; phase++) begin
      settle();
      grid = (phase < FIXED_GRIDS) ? fixed_grids[phase] : random_grid();
      program_grid(grid);
      // Every third phase runs with both sides at full rate.
      idle_on = (phase % 3 != 1);
      for (n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 59) == 0) drain_results();
        push_item(make_item(), 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("voxel_histogram_3d_test: PASS");
    end else begin
      $display("voxel_histogram_3d_test: FAIL");
    end
    $finish;
  end

  // The result side stalls at random, in both short and long stretches.
  initial begin : result_sink
    int unsigned stall;
    int unsigned hold;
    out_ch.ready = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ch.ready <= 1'b1;
      hold = $urandom_range(0, 6);
      repeat (hold) @(negedge clk_i);
    end
  end

  // Each result beat is matched against the oldest outcome still queued.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_bins.size() == 0) begin
        $error("unexpected result beat: bin_address %0d, bin_count %0d, out_of_range %0b",
               out_ch.data.bin_address, out_ch.data.bin_count, out_ch.data.out_of_range);
        fail_count++;
      end else begin
        head_bin = awaited_bins.pop_front();
        if (out_ch.data.bin_address !== head_bin.bin_address) begin
          $error("bin_address mismatch: expected %0d, got %0d",
                 head_bin.bin_address, out_ch.data.bin_address);
          fail_count++;
        end
        if (out_ch.data.bin_count !== head_bin.bin_count) begin
          $error("bin_count mismatch: expected %0d, got %0d",
                 head_bin.bin_count, out_ch.data.bin_count);
          fail_count++;
        end
        if (out_ch.data.out_of_range !== head_bin.out_of_range) begin
          $error("out_of_range mismatch: expected %0b, got %0b",
                 head_bin.out_of_range, out_ch.data.out_of_range);
          fail_count++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("voxel_histogram_3d_test: FAIL");
      $finish;
    end
  end

endmodule

// ===== voxel_histogram_3d.f =====
design/vh3d_pkg.sv
design/vh3d_chan_if.sv
design/vh3d_ram.sv
design/voxel_histogram_3d.sv
sim/voxel_histogram_3d_test.sv
